/* hdl/cbl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbl_pkg
// shared types, widths and helpers for the look-at camera basis pipeline
// ----------------------------------------------------------------------------
package cbl_pkg;

  localparam int WORD_W     = 32;
  localparam int WIDE_W     = 64;
  localparam int NORM_W     = 30;  // magnitudes are aligned to this bit length
  localparam int ROOT_STEPS = 32;  // one result bit of the square root per stage
  localparam int BLEN_W     = 7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [2:0][WORD_W-1:0]   vec3_t;
  typedef logic [2:0][WIDE_W-1:0]   wvec3_t;

  typedef struct packed {
    logic look_dn;
    logic look_up;
    logic zero_d;
    logic zero_c;
  } flags_t;

  typedef struct packed {
    vec3_t  u;
    vec3_t  w;
    flags_t flg;
  } ctx_t;

  // bit length of a wide magnitude, zero for zero
  function automatic logic [BLEN_W-1:0] bit_len(input logic [WIDE_W-1:0] v);
    logic [BLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (v[i]) n = BLEN_W'(i + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* hdl/camera_basis_from_lookat_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// camera_basis_from_lookat_top
// look-at camera basis: w = norm(eye - target), u = norm(up x w), v = w x u
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  in_     | in_valid/in_stall  | eye, target, up vector, signed Q16.16
//  out_    | out_valid/out_stall| right, upward, back in Q1.30, degenerate
//
//  one word accepted per cycle while no finished result is held by out_stall
//  most of the depth lies in the two normalize units: 32 square root stages and
//  UNIT_FRAC_BITS+1 divider stages each
//  synchronous active-low reset clears every valid bit, payload is not reset
//  a held result stalls every stage at once, nothing is dropped or repeated
// ----------------------------------------------------------------------------
module camera_basis_from_lookat_top #(
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cbl_pkg::word_t in_eye_x,
  input  cbl_pkg::word_t in_eye_y,
  input  cbl_pkg::word_t in_eye_z,
  input  cbl_pkg::word_t in_target_x,
  input  cbl_pkg::word_t in_target_y,
  input  cbl_pkg::word_t in_target_z,
  input  cbl_pkg::word_t in_upvec_x,
  input  cbl_pkg::word_t in_upvec_y,
  input  cbl_pkg::word_t in_upvec_z,
  output logic           out_valid,
  input  logic           out_stall,
  output cbl_pkg::word_t out_right_x,
  output cbl_pkg::word_t out_right_y,
  output cbl_pkg::word_t out_right_z,
  output cbl_pkg::word_t out_upward_x,
  output cbl_pkg::word_t out_upward_y,
  output cbl_pkg::word_t out_upward_z,
  output cbl_pkg::word_t out_back_x,
  output cbl_pkg::word_t out_back_y,
  output cbl_pkg::word_t out_back_z,
  output logic           out_degenerate
);

  localparam cbl_pkg::word_t ONE  = cbl_pkg::word_t'(1) <<< UNIT_FRAC_BITS;
  localparam cbl_pkg::wide_t HALF = cbl_pkg::wide_t'(1) <<< (UNIT_FRAC_BITS - 1);

  typedef struct packed {
    cbl_pkg::vec3_t up;
    logic           dn;
    logic           upl;
  } side1_t;

  typedef struct packed {
    cbl_pkg::vec3_t  w;
    cbl_pkg::flags_t flg;
  } side2_t;

  // whole pipeline moves unless a finished word is held
  logic adv;

  logic            s0_vld_r;
  cbl_pkg::wvec3_t s0_d_r;
  side1_t          s0_side_r;

  logic            n1_vld, n1_zero;
  cbl_pkg::vec3_t  n1_w;
  side1_t          n1_side;

  logic              x1_vld_r, x2_vld_r;
  logic [5:0][63:0]  x1_p_r;
  side2_t            x1_side_r, x2_side_r;
  cbl_pkg::wvec3_t   x2_c_r;
  cbl_pkg::flags_t   x1_flg;

  logic            n2_vld, n2_zero;
  cbl_pkg::vec3_t  n2_u;
  side2_t          n2_side;

  logic              v1_vld_r, v2_vld_r, v3_vld_r, v4_vld_r;
  cbl_pkg::ctx_t     v1_ctx_r, v2_ctx_r, v3_ctx_r, v4_ctx_r;
  cbl_pkg::ctx_t     v1_ctx_nxt;
  logic [5:0][63:0]  v1_p_r;
  cbl_pkg::wvec3_t   v2_d_r, v3_m_r, v4_r_r;
  logic [2:0]        v3_neg_r, v4_neg_r;
  cbl_pkg::vec3_t    v_nxt;

  logic            out_valid_r;
  cbl_pkg::vec3_t  out_u_r, out_v_r, out_w_r;
  logic            out_degen_r;
  cbl_pkg::vec3_t  u_nxt, v_sel, w_nxt;
  logic            degen_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 0: difference and vertical look checks ------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_d_r[0]     <= cbl_pkg::wide_t'(in_eye_x) - cbl_pkg::wide_t'(in_target_x);
      s0_d_r[1]     <= cbl_pkg::wide_t'(in_eye_y) - cbl_pkg::wide_t'(in_target_y);
      s0_d_r[2]     <= cbl_pkg::wide_t'(in_eye_z) - cbl_pkg::wide_t'(in_target_z);
      s0_side_r.up  <= {in_upvec_z, in_upvec_y, in_upvec_x};
      s0_side_r.dn  <= (in_eye_x == in_target_x) && (in_eye_z == in_target_z) &&
                       (in_eye_y > in_target_y);
      s0_side_r.upl <= (in_eye_x == in_target_x) && (in_eye_z == in_target_z) &&
                       (in_eye_y < in_target_y);
    end
  end

  // ---------------- w = normalize(eye - target) ------------------------------
  cbl_norm #(.UF(UNIT_FRAC_BITS), .SIDE_W($bits(side1_t))) u_norm_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s0_vld_r),
    .in_vec   (s0_d_r),
    .in_side  (s0_side_r),
    .out_vld  (n1_vld),
    .out_unit (n1_w),
    .out_zero (n1_zero),
    .out_side (n1_side)
  );

  // ---------------- c = up x w: products then differences -------------------
  always_comb begin
    x1_flg.look_dn = n1_side.dn;
    x1_flg.look_up = n1_side.upl;
    x1_flg.zero_d  = n1_zero;
    x1_flg.zero_c  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
    end else if (adv) begin
      x1_vld_r <= n1_vld;
      x2_vld_r <= x1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_p_r[0] <= $signed(n1_side.up[1]) * $signed(n1_w[2]);
      x1_p_r[1] <= $signed(n1_side.up[2]) * $signed(n1_w[1]);
      x1_p_r[2] <= $signed(n1_side.up[2]) * $signed(n1_w[0]);
      x1_p_r[3] <= $signed(n1_side.up[0]) * $signed(n1_w[2]);
      x1_p_r[4] <= $signed(n1_side.up[0]) * $signed(n1_w[1]);
      x1_p_r[5] <= $signed(n1_side.up[1]) * $signed(n1_w[0]);
      x1_side_r.w   <= n1_w;
      x1_side_r.flg <= x1_flg;
      x2_c_r[0] <= x1_p_r[0] - x1_p_r[1];
      x2_c_r[1] <= x1_p_r[2] - x1_p_r[3];
      x2_c_r[2] <= x1_p_r[4] - x1_p_r[5];
      x2_side_r <= x1_side_r;
    end
  end

  // ---------------- u = normalize(c) -----------------------------------------
  cbl_norm #(.UF(UNIT_FRAC_BITS), .SIDE_W($bits(side2_t))) u_norm_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (x2_vld_r),
    .in_vec   (x2_c_r),
    .in_side  (x2_side_r),
    .out_vld  (n2_vld),
    .out_unit (n2_u),
    .out_zero (n2_zero),
    .out_side (n2_side)
  );

  // ---------------- v = w x u, scaled back with rounding --------------------
  always_comb begin
    v1_ctx_nxt.u          = n2_u;
    v1_ctx_nxt.w          = n2_side.w;
    v1_ctx_nxt.flg        = n2_side.flg;
    v1_ctx_nxt.flg.zero_c = n2_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_vld_r <= 1'b0;
      v2_vld_r <= 1'b0;
      v3_vld_r <= 1'b0;
      v4_vld_r <= 1'b0;
    end else if (adv) begin
      v1_vld_r <= n2_vld;
      v2_vld_r <= v1_vld_r;
      v3_vld_r <= v2_vld_r;
      v4_vld_r <= v3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_p_r[0] <= $signed(n2_side.w[1]) * $signed(n2_u[2]);
      v1_p_r[1] <= $signed(n2_side.w[2]) * $signed(n2_u[1]);
      v1_p_r[2] <= $signed(n2_side.w[2]) * $signed(n2_u[0]);
      v1_p_r[3] <= $signed(n2_side.w[0]) * $signed(n2_u[2]);
      v1_p_r[4] <= $signed(n2_side.w[0]) * $signed(n2_u[1]);
      v1_p_r[5] <= $signed(n2_side.w[1]) * $signed(n2_u[0]);
      v1_ctx_r  <= v1_ctx_nxt;
      v2_d_r[0] <= v1_p_r[0] - v1_p_r[1];
      v2_d_r[1] <= v1_p_r[2] - v1_p_r[3];
      v2_d_r[2] <= v1_p_r[4] - v1_p_r[5];
      v2_ctx_r  <= v1_ctx_r;
      for (int i = 0; i < 3; i++) begin
        v3_neg_r[i] <= v2_d_r[i][63];
        v3_m_r[i]   <= v2_d_r[i][63] ? (~v2_d_r[i]) + 64'd1 : v2_d_r[i];
        v4_r_r[i]   <= (v3_m_r[i] + HALF) >> UNIT_FRAC_BITS;
      end
      v3_ctx_r <= v2_ctx_r;
      v4_neg_r <= v3_neg_r;
      v4_ctx_r <= v3_ctx_r;
    end
  end

  // clamp the rounded magnitude to one, then apply the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [63:0] r;
      r = (v4_r_r[i] > 64'(ONE)) ? 64'(ONE) : v4_r_r[i];
      v_nxt[i] = v4_neg_r[i] ? 32'(-r) : 32'(r);
    end
  end

  // ---------------- final select: vertical looks, degenerate, computed ------
  always_comb begin
    priority if (v4_ctx_r.flg.look_dn) begin
      u_nxt     = {ONE, 32'sd0, 32'sd0};
      v_sel     = {32'sd0, 32'sd0, ONE};
      w_nxt     = {32'sd0, ONE, 32'sd0};
      degen_nxt = 1'b0;
    end else if (v4_ctx_r.flg.look_up) begin
      u_nxt     = {32'sd0, 32'sd0, ONE};
      v_sel     = {ONE, 32'sd0, 32'sd0};
      w_nxt     = {32'sd0, -ONE, 32'sd0};
      degen_nxt = 1'b0;
    end else if (v4_ctx_r.flg.zero_d || v4_ctx_r.flg.zero_c) begin
      u_nxt     = '0;
      v_sel     = '0;
      w_nxt     = '0;
      degen_nxt = 1'b1;
    end else begin
      u_nxt     = v4_ctx_r.u;
      v_sel     = v_nxt;
      w_nxt     = v4_ctx_r.w;
      degen_nxt = 1'b0;
    end
  end

  // output register parts the pipeline from the result side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_u_r     <= u_nxt;
      out_v_r     <= v_sel;
      out_w_r     <= w_nxt;
      out_degen_r <= degen_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_right_x    = out_u_r[0];
  assign out_right_y    = out_u_r[1];
  assign out_right_z    = out_u_r[2];
  assign out_upward_x   = out_v_r[0];
  assign out_upward_y   = out_v_r[1];
  assign out_upward_z   = out_v_r[2];
  assign out_back_x     = out_w_r[0];
  assign out_back_y     = out_w_r[1];
  assign out_back_z     = out_w_r[2];
  assign out_degenerate = out_degen_r;

  // ---------------- checks ---------------------------------------------------
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_right_x == 0 && out_right_y == 0 && out_right_z == 0 &&
       out_upward_x == 0 && out_upward_y == 0 && out_upward_z == 0 &&
       out_back_x == 0 && out_back_y == 0 && out_back_z == 0))
    else $error("degenerate word carries a nonzero vector");

  a_back_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (out_back_x != 0 || out_back_y != 0 || out_back_z != 0))
    else $error("valid basis with a zero back vector");

  a_right_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_right_x <= ONE && out_right_x >= -ONE &&
                   out_back_y <= ONE && out_back_y >= -ONE))
    else $error("unit component beyond one");

  a_hold_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s0_vld_r))
    else $error("first stage moved during a stall");

endmodule
`default_nettype wire

/* hdl/cbl_isqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbl_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module cbl_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  localparam int STEPS = cbl_pkg::ROOT_STEPS;

  logic [63:0] n_r [STEPS];
  logic [63:0] r_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (2 * (STEPS - 1 - k));
    logic [63:0] n_in;
    logic [63:0] r_in;
    logic [63:0] n_nxt;
    logic [63:0] r_nxt;

    if (k == 0) begin : g_first
      assign n_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
    end

    always_comb begin
      if (n_in >= r_in + BIT) begin
        n_nxt = n_in - (r_in + BIT);
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        n_nxt = n_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_nxt;
        r_r[k] <= r_nxt;
      end
    end
  end

  assign root = r_r[STEPS-1][31:0];

endmodule
`default_nettype wire

/* hdl/cbl_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbl_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cbl_div #(
  parameter int NUM_W = 61,
  parameter int QB    = 31
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic [QB-1:0]    quo
);

  // quotient is known to fit in QB bits, so the top of num starts as remainder
  logic [32:0]      rem_r [QB-1];
  logic [NUM_W-1:0] num_r [QB-1];
  logic [31:0]      den_r [QB-1];
  logic [QB-1:0]    q_r   [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [32:0]      rem_in;
    logic [NUM_W-1:0] num_in;
    logic [31:0]      den_in;
    logic [QB-1:0]    q_in;
    logic [32:0]      sh;
    logic [32:0]      rem_nxt;
    logic             qbit;

    if (j == 0) begin : g_first
      assign rem_in = 33'(num >> QB);
      assign num_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign num_in = num_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    always_comb begin
      sh = {rem_in[31:0], num_in[QB-1-j]};
      if (sh >= {1'b0, den_in}) begin
        rem_nxt = sh - {1'b0, den_in};
        qbit    = 1'b1;
      end else begin
        rem_nxt = sh;
        qbit    = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= {q_in[QB-2:0], qbit};
      end
    end

    if (j < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= rem_nxt;
          num_r[j] <= num_in;
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[QB-1];

endmodule
`default_nettype wire

/* hdl/cbl_norm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbl_norm
// pipelined vector normalize: align, sum of squares, root, three divides
// ----------------------------------------------------------------------------
module cbl_norm #(
  parameter int UF     = 30,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  cbl_pkg::wvec3_t     in_vec,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output cbl_pkg::vec3_t      out_unit,
  output logic                out_zero,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int NW    = cbl_pkg::NORM_W;
  localparam int WW    = cbl_pkg::WIDE_W;
  localparam int RS    = cbl_pkg::ROOT_STEPS;
  localparam int NUM_W = NW + UF + 1;
  localparam int QB    = UF + 1;
  localparam logic [QB-1:0] ONE = QB'(1) << UF;

  typedef struct packed {
    logic [SIDE_W-1:0]   side;
    logic                zero;
    logic [2:0]          neg;
    logic [2:0][NW-1:0]  sm;
  } meta_a_t;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              zero;
    logic [2:0]        neg;
  } meta_b_t;

  // magnitudes and signs
  logic                 vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r;
  cbl_pkg::wvec3_t      mag1_r, mag2_r;
  logic [2:0]           neg1_r, neg2_r;
  logic [SIDE_W-1:0]    side1_r, side2_r;
  logic [cbl_pkg::BLEN_W-1:0] blen2_r;
  meta_a_t              ma3_r, ma4_r, ma5_r;
  logic [2:0][63:0]     sq4_r;
  logic [63:0]          sum5_r;
  logic [31:0]          root;
  logic [RS-1:0]        va_r;
  meta_a_t              ma_r [RS];
  logic [2:0][NUM_W-1:0] num6_r;
  logic [31:0]          len6_r;
  meta_b_t              mb6_r;
  logic [QB-1:0]        vb_r;
  meta_b_t              mb_r [QB];
  logic [2:0][QB-1:0]   quo;
  meta_a_t              ma3_nxt;
  logic [2:0][NUM_W-1:0] num6_nxt;
  cbl_pkg::vec3_t       unit_nxt;
  cbl_pkg::vec3_t       out_unit_r;
  logic                 out_zero_r, out_vld_r;
  logic [SIDE_W-1:0]    out_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      vld4_r    <= 1'b0;
      vld5_r    <= 1'b0;
      vld6_r    <= 1'b0;
      va_r      <= '0;
      vb_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld1_r    <= in_vld;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      vld4_r    <= vld3_r;
      vld5_r    <= vld4_r;
      va_r      <= {va_r[RS-2:0], vld5_r};
      vld6_r    <= va_r[RS-1];
      vb_r      <= {vb_r[QB-2:0], vld6_r};
      out_vld_r <= vb_r[QB-1];
    end
  end

  // alignment so the largest magnitude has exactly NW bits
  always_comb begin
    ma3_nxt.side = side2_r;
    ma3_nxt.neg  = neg2_r;
    ma3_nxt.zero = (blen2_r == '0);
    for (int i = 0; i < 3; i++) begin
      if (blen2_r > cbl_pkg::BLEN_W'(NW)) begin
        ma3_nxt.sm[i] = NW'(mag2_r[i] >> (blen2_r - cbl_pkg::BLEN_W'(NW)));
      end else begin
        ma3_nxt.sm[i] = NW'(mag2_r[i] << (cbl_pkg::BLEN_W'(NW) - blen2_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= in_vec[i][WW-1];
        mag1_r[i] <= in_vec[i][WW-1] ? (~in_vec[i]) + 64'd1 : in_vec[i];
        sq4_r[i]  <= 64'(ma3_r.sm[i]) * 64'(ma3_r.sm[i]);
      end
      side1_r <= in_side;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      side2_r <= side1_r;
      blen2_r <= cbl_pkg::bit_len(mag1_r[0] | mag1_r[1] | mag1_r[2]);
      ma3_r   <= ma3_nxt;
      ma4_r   <= ma3_r;
      sum5_r  <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      ma5_r   <= ma4_r;
      ma_r[0] <= ma5_r;
      for (int k = 1; k < RS; k++) ma_r[k] <= ma_r[k-1];
    end
  end

  cbl_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum5_r),
    .root     (root)
  );

  // rounded numerators, half the length added ahead of the divide
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num6_nxt[i] = (NUM_W'(ma_r[RS-1].sm[i]) << UF) + NUM_W'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num6_r     <= num6_nxt;
      len6_r     <= root;
      mb6_r.side <= ma_r[RS-1].side;
      mb6_r.zero <= ma_r[RS-1].zero;
      mb6_r.neg  <= ma_r[RS-1].neg;
      mb_r[0]    <= mb6_r;
      for (int k = 1; k < QB; k++) mb_r[k] <= mb_r[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    cbl_div #(.NUM_W(NUM_W), .QB(QB)) u_div (
      .clk (clk),
      .en  (en),
      .num (num6_r[i]),
      .den (len6_r),
      .quo (quo[i])
    );
  end

  // clamp to one and restore the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [QB-1:0] q;
      q = (quo[i] > ONE) ? ONE : quo[i];
      unit_nxt[i] = mb_r[QB-1].neg[i] ? 32'(-32'(q)) : 32'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_unit_r <= unit_nxt;
      out_zero_r <= mb_r[QB-1].zero;
      out_side_r <= mb_r[QB-1].side;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_unit = out_unit_r;
  assign out_zero = out_zero_r;
  assign out_side = out_side_r;

endmodule
`default_nettype wire
